>>> src/fus_pkg.sv
// ----------------------------------------------------------------------------
// fus_pkg
// Shared types, codes and result builders of the firmware upload sequencer.
// ----------------------------------------------------------------------------
package fus_pkg;

	localparam int MAX_RESULTS = 3;
	localparam int CFG_IDX_W   = 4;

	localparam logic [5:0]  CODE_MASK            = 6'h3F;
	localparam logic [1:0]  SILENT_LIMIT         = 2'd3;
	localparam logic [15:0] SESSION_START        = 16'd1;
	localparam logic [8:0]  DEFAULT_PACKET_BYTES = 9'd64;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PACKET_COUNT  = 4'd0,
		REG_PACKET_BYTES  = 4'd1,
		REG_IMAGE_CRC     = 4'd2,
		REG_IMAGE_VERSION = 4'd3,
		REG_REQUEST_CODE  = 4'd4,
		REG_DATA_CODE     = 4'd5,
		REG_VERIFY_CODE   = 4'd6,
		REG_RESTART_CODE  = 4'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_START = 2'd0,
		MODE_RESP  = 2'd1,
		MODE_TICK  = 2'd2
	} mode_t;

	localparam logic OUT_FRAME = 1'b0;
	localparam logic OUT_EVENT = 1'b1;

	localparam logic [2:0] EV_REQUEST  = 3'd0;
	localparam logic [2:0] EV_DATA     = 3'd1;
	localparam logic [2:0] EV_VERIFY   = 3'd2;
	localparam logic [2:0] EV_COMPLETE = 3'd3;
	localparam logic [2:0] EV_TIMEOUT  = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_MISMATCH = 2'd1;
	localparam logic [1:0] ST_DEV_ERR  = 2'd2;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] target_id;
		logic [31:0] term_id;
		logic [7:0]  group_id;
		logic [5:0]  resp_code;
		logic [7:0]  ack;
		logic [15:0] resp_session;
		logic [15:0] resp_index;
	} item_t;

	typedef struct packed {
		logic        out_kind;
		logic [5:0]  frame_cmd;
		logic [31:0] frame_target;
		logic [15:0] frame_session;
		logic [31:0] frame_arg;
		logic [2:0]  event_kind;
		logic [7:0]  event_group;
		logic [1:0]  event_status;
		logic [31:0] event_arg;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [15:0] packet_count;
		logic [8:0]  packet_bytes;
		logic [15:0] image_crc;
		logic [31:0] image_version;
		logic [5:0]  request_code;
		logic [5:0]  data_code;
		logic [5:0]  verify_code;
		logic [5:0]  restart_code;
	} cfg_t;

	// results caused by one item, in order
	typedef struct packed {
		logic [1:0]                 count;
		result_t [MAX_RESULTS-1:0] res;
	} group_t;

	function automatic result_t mk_frame(logic [5:0] cmd, logic [31:0] tgt,
		logic [15:0] sess, logic [31:0] arg);
		result_t r;
		r               = '0;
		r.out_kind      = OUT_FRAME;
		r.frame_cmd     = cmd & CODE_MASK;
		r.frame_target  = tgt;
		r.frame_session = sess;
		r.frame_arg     = arg;
		return r;
	endfunction

	function automatic result_t mk_event(logic [2:0] kind, logic [31:0] tgt,
		logic [7:0] grp, logic [1:0] status, logic [31:0] arg);
		result_t r;
		r              = '0;
		r.out_kind     = OUT_EVENT;
		r.frame_target = tgt;
		r.event_kind   = kind;
		r.event_group  = grp;
		r.event_status = status;
		r.event_arg    = arg;
		return r;
	endfunction

endpackage

>>> src/fus_core.sv
// ----------------------------------------------------------------------------
// fus_core
// Upload state and the single-pass decision logic for one registered item.
// ----------------------------------------------------------------------------
module fus_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  fus_pkg::item_t  item,
	input  fus_pkg::cfg_t   cfg,
	output fus_pkg::group_t group
);
	import fus_pkg::*;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_REQ    = 2'd1,
		PH_DATA   = 2'd2,
		PH_VERIFY = 2'd3
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [31:0] target_q, target_n;
	logic [15:0] sess_ctr_q, sess_ctr_n;
	logic [15:0] act_sess_q, act_sess_n;
	logic [15:0] idx_q, idx_n;
	logic [1:0]  silent_q, silent_n;

	logic        send;
	logic        ev_v;
	logic        fr_v;
	logic        done;
	result_t     ev;
	result_t     fr;
	logic [15:0] idx_inc;
	logic [31:0] total_size;

	assign idx_inc    = (idx_q == 16'hFFFF) ? idx_q : idx_q + 16'd1;
	assign total_size = {7'd0, 25'(cfg.packet_count) * 25'(cfg.packet_bytes)};

	always_comb begin
		phase_n    = phase_q;
		target_n   = target_q;
		sess_ctr_n = sess_ctr_q;
		act_sess_n = act_sess_q;
		idx_n      = idx_q;
		silent_n   = silent_q;
		send       = 1'b0;
		ev_v       = 1'b0;
		ev         = '0;
		done       = 1'b0;

		unique case (item.mode)
			MODE_START: begin
				if (phase_q == PH_IDLE) begin
					target_n   = item.target_id;
					act_sess_n = sess_ctr_q;
					sess_ctr_n = sess_ctr_q + 16'd1;
					phase_n    = PH_REQ;
					idx_n      = '0;
					silent_n   = '0;
					send       = 1'b1;
				end
			end
			MODE_RESP: begin
				if (phase_q != PH_IDLE) begin
					silent_n = '0;
					send     = 1'b1;
					if (item.term_id == target_q) begin
						priority if (item.resp_code == cfg.request_code) begin
							ev_v = 1'b1;
							if (item.resp_session != act_sess_q) begin
								ev = mk_event(EV_REQUEST, target_q, item.group_id,
									ST_MISMATCH, '0);
							end else if (item.ack == '0) begin
								idx_n   = '0;
								phase_n = PH_DATA;
								ev = mk_event(EV_REQUEST, target_q, item.group_id,
									ST_OK, '0);
							end else begin
								ev = mk_event(EV_REQUEST, target_q, item.group_id,
									ST_DEV_ERR, {24'd0, item.ack});
							end
						end else if (item.resp_code == cfg.data_code) begin
							ev_v = 1'b1;
							if (item.resp_session != act_sess_q) begin
								ev = mk_event(EV_DATA, target_q, item.group_id,
									ST_MISMATCH, '0);
							end else if (item.ack == '0) begin
								idx_n = idx_inc;
								if (idx_inc >= cfg.packet_count) begin
									phase_n = PH_VERIFY;
								end
								ev = mk_event(EV_DATA, target_q, item.group_id,
									ST_OK, {cfg.packet_count, idx_inc});
							end else begin
								ev = mk_event(EV_DATA, target_q, item.group_id,
									ST_DEV_ERR, {24'd0, item.ack});
							end
						end else if (item.resp_code == cfg.verify_code) begin
							ev_v = 1'b1;
							if (item.resp_session != act_sess_q) begin
								// verify mismatch is reported as a request event
								ev = mk_event(EV_REQUEST, target_q, item.group_id,
									ST_MISMATCH, '0);
							end else if (item.ack == '0) begin
								done     = 1'b1;
								send     = 1'b0;
								phase_n  = PH_IDLE;
								target_n = '0;
								idx_n    = '0;
								ev = mk_event(EV_VERIFY, target_q, item.group_id,
									ST_OK, '0);
							end else begin
								ev = mk_event(EV_VERIFY, target_q, item.group_id,
									ST_DEV_ERR, {24'd0, item.ack});
							end
						end else begin
							ev_v = 1'b0;
						end
					end
				end
			end
			MODE_TICK: begin
				if (phase_q != PH_IDLE) begin
					if (silent_q >= SILENT_LIMIT) begin
						ev_v     = 1'b1;
						ev       = mk_event(EV_TIMEOUT, target_q, '0, ST_OK, '0);
						phase_n  = PH_IDLE;
						target_n = '0;
						idx_n    = '0;
						silent_n = '0;
					end else begin
						silent_n = silent_q + 2'd1;
						send     = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// frame of the phase the item leads into
	always_comb begin
		fr   = '0;
		fr_v = 1'b0;
		unique case (phase_n)
			PH_IDLE: begin
				fr_v = 1'b0;
			end
			PH_REQ: begin
				fr_v = send;
				fr   = mk_frame(cfg.request_code, target_n, act_sess_n, total_size);
			end
			PH_DATA: begin
				fr_v = send && (idx_n < cfg.packet_count);
				fr   = mk_frame(cfg.data_code, target_n, act_sess_n, {16'd0, idx_n});
			end
			PH_VERIFY: begin
				fr_v = send;
				fr   = mk_frame(cfg.verify_code, target_n, act_sess_n,
					{16'd0, cfg.image_crc});
			end
		endcase
	end

	// pack results in order and mark the final one
	always_comb begin
		group = '0;
		if (done) begin
			group.count  = 2'd3;
			group.res[0] = ev;
			group.res[1] = mk_event(EV_COMPLETE, target_q, item.group_id, ST_OK,
				cfg.image_version);
			group.res[2] = mk_frame(cfg.restart_code, target_q, act_sess_q, '0);
			group.res[2].last = 1'b1;
		end else if (ev_v) begin
			group.res[0] = ev;
			if (fr_v) begin
				group.count  = 2'd2;
				group.res[1] = fr;
				group.res[1].last = 1'b1;
			end else begin
				group.count  = 2'd1;
				group.res[0].last = 1'b1;
			end
		end else if (fr_v) begin
			group.count  = 2'd1;
			group.res[0] = fr;
			group.res[0].last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			target_q   <= '0;
			sess_ctr_q <= SESSION_START;
			act_sess_q <= '0;
			idx_q      <= '0;
			silent_q   <= '0;
		end else if (fire) begin
			phase_q    <= phase_n;
			target_q   <= target_n;
			sess_ctr_q <= sess_ctr_n;
			act_sess_q <= act_sess_n;
			idx_q      <= idx_n;
			silent_q   <= silent_n;
		end
	end

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> (target_q == '0 && idx_q == '0 && silent_q == '0))
		else $error("idle with stale upload state");

	a_session_step: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item.mode == MODE_START && phase_q == PH_IDLE)
		|=> (sess_ctr_q == $past(sess_ctr_q) + 16'd1 && act_sess_q == $past(sess_ctr_q)))
		else $error("session number not taken from counter");

	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && phase_q == PH_IDLE) |-> (group.count <= 2'd1))
		else $error("idle item produced more than the request frame");

endmodule

>>> src/fus_emitter.sv
// ----------------------------------------------------------------------------
// fus_emitter
// Result register: holds one item's results and hands them out one by one.
// ----------------------------------------------------------------------------
module fus_emitter (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  fus_pkg::group_t  group,
	output logic             free,
	output logic             result_valid,
	input  logic             result_stall,
	output fus_pkg::result_t result
);
	import fus_pkg::*;

	result_t [MAX_RESULTS-1:0] res_q;
	logic [1:0]                left_q;
	logic [1:0]                pos_q;
	logic                      take;

	assign result_valid = (left_q != 2'd0);
	assign take         = result_valid && !result_stall;
	assign free         = (left_q == 2'd0) || (left_q == 2'd1 && take);
	assign result       = res_q[pos_q];

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= group.res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			pos_q  <= '0;
		end else if (load) begin
			left_q <= group.count;
			pos_q  <= '0;
		end else if (take) begin
			left_q <= left_q - 2'd1;
			pos_q  <= pos_q + 2'd1;
		end
	end

	a_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ({1'b0, pos_q} + {1'b0, left_q} <= 3'(MAX_RESULTS)))
		else $error("result position runs past the stored group");

	a_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.last == (left_q == 2'd1)))
		else $error("last flag does not match remaining results");

endmodule

>>> src/firmware_upload_sequencer_top.sv
// ----------------------------------------------------------------------------
// firmware_upload_sequencer_top
// Sender side of a packetized firmware upload to one device. Start, decoded
// response and silent tick transactions arrive on the item channel; frames to
// send and event notifications leave on the result channel, the final result
// of each item carrying last. An item is registered on acceptance and decided
// in one pass once the result register can take its group, updating the upload
// state and loading its zero to three results into the result register. A new
// item is taken every cycle while the result register can be refilled. It
// hands out one result per cycle unless the result channel stalls, and is
// refilled once its last result is taken. Payload bytes are not carried here:
// the host reads them at the packet index in each data frame. Configuration
// writes are always ready and must only happen while idle.
// ----------------------------------------------------------------------------
module firmware_upload_sequencer_top (
	input  logic                            clk,
	input  logic                            arst_n,
	// item channel
	input  logic                            item_valid,
	output logic                            item_stall,
	input  fus_pkg::item_t                  item,
	// result channel
	output logic                            result_valid,
	input  logic                            result_stall,
	output fus_pkg::result_t                result,
	// configuration write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [fus_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [31:0]                     cfg_data
);
	import fus_pkg::*;

	cfg_t   cfg_q;
	item_t  item_s1;
	logic   valid_s1;
	logic   free;
	logic   fire;
	logic   item_take;
	group_t group;

	// register writes are always accepted
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.packet_count  <= 16'd1;
			cfg_q.packet_bytes  <= DEFAULT_PACKET_BYTES;
			cfg_q.image_crc     <= '0;
			cfg_q.image_version <= '0;
			cfg_q.request_code  <= 6'd1;
			cfg_q.data_code     <= 6'd2;
			cfg_q.verify_code   <= 6'd3;
			cfg_q.restart_code  <= 6'd4;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PACKET_COUNT:  cfg_q.packet_count  <= cfg_data[15:0];
				REG_PACKET_BYTES:  cfg_q.packet_bytes  <= cfg_data[8:0];
				REG_IMAGE_CRC:     cfg_q.image_crc     <= cfg_data[15:0];
				REG_IMAGE_VERSION: cfg_q.image_version <= cfg_data;
				REG_REQUEST_CODE:  cfg_q.request_code  <= cfg_data[5:0];
				REG_DATA_CODE:     cfg_q.data_code     <= cfg_data[5:0];
				REG_VERIFY_CODE:   cfg_q.verify_code   <= cfg_data[5:0];
				REG_RESTART_CODE:  cfg_q.restart_code  <= cfg_data[5:0];
				default: begin
					// drop writes to unused indexes
				end
			endcase
		end
	end

	// Decide the registered item once the result register can take its group;
	// hold the input stage otherwise.
	assign fire       = valid_s1 && free;
	assign item_stall = valid_s1 && !free;
	assign item_take  = item_valid && !item_stall;

	always_ff @(posedge clk) begin
		if (item_take) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	fus_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg_q),
		.group  (group)
	);

	// load even an empty group so the stage drains cleanly
	fus_emitter u_emitter (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (fire),
		.group        (group),
		.free         (free),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	a_stall_pending: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (valid_s1 && result_valid))
		else $error("input stalled with nothing pending downstream");

endmodule

>>> tb/tb_firmware_upload_sequencer_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_firmware_upload_sequencer_top
// Self-checking bench for the firmware upload sequencer. A clocked driver
// feeds start, response and tick transactions from a queue of pending items.
// On each accepted transaction a predictor of the upload state machine adds
// the frames and events it must cause to a queue of expected results, and a
// clocked monitor compares every accepted result with the oldest of them.
// ----------------------------------------------------------------------------
module tb_firmware_upload_sequencer_top;
	import fus_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int PRINT_LIMIT    = 40;

	localparam logic [1:0] MODE_UNUSED = 2'd3;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_REQ    = 2'd1,
		PH_DATA   = 2'd2,
		PH_VERIFY = 2'd3
	} phase_e;

	typedef enum int {
		STALL_NONE,
		STALL_RANDOM,
		STALL_PERIODIC
	} stall_style_e;

	// upload progress as the block should hold it
	typedef struct packed {
		phase_e      phase;
		logic [31:0] target;
		logic [15:0] session_ctr;
		logic [15:0] session;
		logic [15:0] pkt_idx;
		logic [1:0]  silent;
	} upload_state_t;

	localparam upload_state_t UPLOAD_IDLE = '{PH_IDLE, 32'd0, SESSION_START, 16'd0, 16'd0,
		2'd0};

	logic                   clk          = 1'b0;
	logic                   arst_n       = 1'b0;
	logic                   item_valid   = 1'b0;
	logic                   item_stall;
	item_t                  item         = '0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	result_t                result;
	logic                   cfg_valid    = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index    = '0;
	logic [31:0]            cfg_data     = '0;

	// register contents, mirrored on every accepted write
	cfg_t upload_cfg = '{16'd1, DEFAULT_PACKET_BYTES, 16'd0, 32'd0, 6'd1, 6'd2, 6'd3, 6'd4};

	// checker copy follows accepted transactions; planning copy follows queued ones
	upload_state_t tracked_upload = UPLOAD_IDLE;
	upload_state_t planned_upload = UPLOAD_IDLE;

	item_t   pending_items[$];
	result_t expected_results[$];

	int  mismatches  = 0;
	int  idle_cycles = 0;
	bit  quiet       = 1'b0;
	bit  drain_pause = 1'b0;
	int  burst_left  = 0;
	int  gap_left    = 0;
	int  bursts_sent = 0;
	int  stall_clock = 0;
	stall_style_e stall_style = STALL_NONE;

	result_t [2:0] step_out;
	int            step_n;
	upload_state_t step_next;
	item_t         next_item;

	firmware_upload_sequencer_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	// frame of the current phase, if that phase has one to (re)send
	function automatic logic phase_frame(upload_state_t s, output result_t r);
		r               = '0;
		r.out_kind      = OUT_FRAME;
		r.frame_target  = s.target;
		r.frame_session = s.session;
		case (s.phase)
			PH_REQ: begin
				r.frame_cmd = upload_cfg.request_code;
				r.frame_arg = {16'd0, upload_cfg.packet_count} * {23'd0, upload_cfg.packet_bytes};
				return 1'b1;
			end
			PH_DATA: begin
				// nothing left to send once every packet has gone out
				if (s.pkt_idx >= upload_cfg.packet_count)
					return 1'b0;
				r.frame_cmd = upload_cfg.data_code;
				r.frame_arg = {16'd0, s.pkt_idx};
				return 1'b1;
			end
			PH_VERIFY: begin
				r.frame_cmd = upload_cfg.verify_code;
				r.frame_arg = {16'd0, upload_cfg.image_crc};
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic result_t notice(logic [2:0] kind, logic [31:0] tgt, logic [7:0] grp,
		logic [1:0] status, logic [31:0] arg);
		result_t r;
		r              = '0;
		r.out_kind     = OUT_EVENT;
		r.frame_target = tgt;
		r.event_kind   = kind;
		r.event_group  = grp;
		r.event_status = status;
		r.event_arg    = arg;
		return r;
	endfunction

	// advance the upload by one transaction and list the results it causes
	function automatic void upload_step(upload_state_t s, item_t it, output upload_state_t ns,
		output result_t [2:0] outs, output int n);
		result_t fr;
		logic    finished;
		ns       = s;
		outs     = '0;
		n        = 0;
		finished = 1'b0;
		case (it.mode)
			MODE_START: begin
				// a start while busy is dropped
				if (s.phase == PH_IDLE) begin
					ns.target      = it.target_id;
					ns.session     = s.session_ctr;
					ns.session_ctr = s.session_ctr + 16'd1;
					ns.phase       = PH_REQ;
					ns.pkt_idx     = '0;
					ns.silent      = '0;
					if (phase_frame(ns, fr)) begin
						outs[n] = fr;
						n       = n + 1;
					end
				end
			end
			MODE_RESP: begin
				if (s.phase != PH_IDLE) begin
					ns.silent = '0;
					// a foreign responder or an unknown code only triggers the resend
					if (it.term_id == s.target) begin
						if (it.resp_code == upload_cfg.request_code) begin
							if (it.resp_session != s.session)
								outs[n] = notice(EV_REQUEST, s.target, it.group_id, ST_MISMATCH, '0);
							else if (it.ack == '0) begin
								ns.pkt_idx = '0;
								ns.phase   = PH_DATA;
								outs[n]    = notice(EV_REQUEST, s.target, it.group_id, ST_OK, '0);
							end else
								outs[n] = notice(EV_REQUEST, s.target, it.group_id, ST_DEV_ERR,
									{24'd0, it.ack});
							n = n + 1;
						end else if (it.resp_code == upload_cfg.data_code) begin
							if (it.resp_session != s.session)
								outs[n] = notice(EV_DATA, s.target, it.group_id, ST_MISMATCH, '0);
							else if (it.ack == '0) begin
								// the index saturates rather than wrapping
								if (ns.pkt_idx != 16'hFFFF)
									ns.pkt_idx = ns.pkt_idx + 16'd1;
								if (ns.pkt_idx >= upload_cfg.packet_count)
									ns.phase = PH_VERIFY;
								outs[n] = notice(EV_DATA, s.target, it.group_id, ST_OK,
									{upload_cfg.packet_count, ns.pkt_idx});
							end else
								outs[n] = notice(EV_DATA, s.target, it.group_id, ST_DEV_ERR,
									{24'd0, it.ack});
							n = n + 1;
						end else if (it.resp_code == upload_cfg.verify_code) begin
							if (it.resp_session != s.session) begin
								// verify mismatch is reported as a request event
								outs[n] = notice(EV_REQUEST, s.target, it.group_id, ST_MISMATCH, '0);
								n       = n + 1;
							end else if (it.ack == '0) begin
								outs[0] = notice(EV_VERIFY, s.target, it.group_id, ST_OK, '0);
								outs[1] = notice(EV_COMPLETE, s.target, it.group_id, ST_OK,
									upload_cfg.image_version);
								outs[2]               = '0;
								outs[2].out_kind      = OUT_FRAME;
								outs[2].frame_cmd     = upload_cfg.restart_code;
								outs[2].frame_target  = s.target;
								outs[2].frame_session = s.session;
								n          = 3;
								ns.phase   = PH_IDLE;
								ns.target  = '0;
								ns.pkt_idx = '0;
								ns.silent  = '0;
								finished   = 1'b1;
							end else begin
								outs[n] = notice(EV_VERIFY, s.target, it.group_id, ST_DEV_ERR,
									{24'd0, it.ack});
								n       = n + 1;
							end
						end
					end
					if (!finished && phase_frame(ns, fr)) begin
						outs[n] = fr;
						n       = n + 1;
					end
				end
			end
			MODE_TICK: begin
				if (s.phase != PH_IDLE) begin
					if (s.silent >= SILENT_LIMIT) begin
						outs[n]    = notice(EV_TIMEOUT, s.target, '0, ST_OK, '0);
						n          = n + 1;
						ns.phase   = PH_IDLE;
						ns.target  = '0;
						ns.pkt_idx = '0;
						ns.silent  = '0;
					end else begin
						ns.silent = s.silent + 2'd1;
						if (phase_frame(ns, fr)) begin
							outs[n] = fr;
							n       = n + 1;
						end
					end
				end
			end
			default: ;
		endcase
		if (n > 0)
			outs[n-1].last = 1'b1;
	endfunction

	// ------------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------------

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		if (mismatches < PRINT_LIMIT)
			$display("%0t: %s: got %h, expected %h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic compare_result(result_t got, result_t want);
		if (got.out_kind !== want.out_kind)
			report_mismatch("out_kind", 32'(got.out_kind), 32'(want.out_kind));
		if (got.frame_cmd !== want.frame_cmd)
			report_mismatch("frame_cmd", 32'(got.frame_cmd), 32'(want.frame_cmd));
		if (got.frame_target !== want.frame_target)
			report_mismatch("frame_target", got.frame_target, want.frame_target);
		if (got.frame_session !== want.frame_session)
			report_mismatch("frame_session", 32'(got.frame_session), 32'(want.frame_session));
		if (got.frame_arg !== want.frame_arg)
			report_mismatch("frame_arg", got.frame_arg, want.frame_arg);
		if (got.event_kind !== want.event_kind)
			report_mismatch("event_kind", 32'(got.event_kind), 32'(want.event_kind));
		if (got.event_group !== want.event_group)
			report_mismatch("event_group", 32'(got.event_group), 32'(want.event_group));
		if (got.event_status !== want.event_status)
			report_mismatch("event_status", 32'(got.event_status), 32'(want.event_status));
		if (got.event_arg !== want.event_arg)
			report_mismatch("event_arg", got.event_arg, want.event_arg);
		if (got.last !== want.last)
			report_mismatch("last", 32'(got.last), 32'(want.last));
	endtask

	// ------------------------------------------------------------------------
	// Driver: predict each accepted transaction, then present the next item.
	// Work in bursts with gaps between them; after some bursts hold off until
	// every expected result has been collected.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (item_valid && !item_stall) begin
			upload_step(tracked_upload, item, step_next, step_out, step_n);
			tracked_upload = step_next;
			for (int k = 0; k < step_n; k++)
				expected_results.push_back(step_out[k]);
		end
		// a stalled transaction keeps its payload and its valid
		if (!item_valid || !item_stall) begin
			if (drain_pause && expected_results.size() != 0) begin
				item_valid <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				item_valid <= 1'b0;
			end else if (pending_items.size() == 0) begin
				item_valid <= 1'b0;
			end else begin
				drain_pause = 1'b0;
				next_item   = pending_items.pop_front();
				item       <= next_item;
				item_valid <= 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					bursts_sent++;
					burst_left  = $urandom_range(1, 12);
					gap_left    = (quiet || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					drain_pause = !quiet && ($urandom_range(0, 15) == 0 || bursts_sent == 3);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: check each accepted result against the oldest expectation and
	// stall on a randomly chosen pattern: none, random or periodic.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0)
					report_mismatch("result with nothing expected", result.frame_arg, '0);
				else
					compare_result(result, expected_results.pop_front());
			end
			stall_clock++;
			if (stall_clock % 97 == 0)
				stall_style = stall_style_e'($urandom_range(0, 2));
			if (quiet)
				result_stall <= 1'b0;
			else begin
				case (stall_style)
					STALL_RANDOM:   result_stall <= ($urandom_range(0, 2) == 0);
					STALL_PERIODIC: result_stall <= (stall_clock % 7 < 4);
					default:        result_stall <= 1'b0;
				endcase
			end
		end
	end

	// end the run when nothing at all moves for too long
	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall) ||
			(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("tb_firmware_upload_sequencer_top failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------

	// queue an item and advance the planning copy; tell whether it does anything
	function automatic int queue_item(item_t it);
		upload_state_t nxt;
		result_t [2:0] outs;
		int            n;
		int            counted;
		upload_step(planned_upload, it, nxt, outs, n);
		counted        = (n != 0 || nxt != planned_upload) ? 1 : 0;
		planned_upload = nxt;
		pending_items.push_back(it);
		return counted;
	endfunction

	function automatic item_t random_item();
		item_t it;
		it.mode         = 2'($urandom_range(0, 3));
		it.target_id    = $urandom();
		it.term_id      = $urandom();
		it.group_id     = 8'($urandom_range(0, 255));
		it.resp_code    = 6'($urandom_range(0, 63));
		it.ack          = 8'($urandom_range(0, 255));
		it.resp_session = 16'($urandom_range(0, 65535));
		it.resp_index   = 16'($urandom_range(0, 65535));
		return it;
	endfunction

	function automatic item_t start_item();
		item_t it;
		it      = random_item();
		it.mode = MODE_START;
		case ($urandom_range(0, 7))
			0:       it.target_id = '0;
			1:       it.target_id = '1;
			default: ;
		endcase
		return it;
	endfunction

	function automatic item_t tick_item();
		item_t it;
		it      = random_item();
		it.mode = MODE_TICK;
		return it;
	endfunction

	// the response a well-behaved device gives in the planned phase
	function automatic item_t next_good_item();
		item_t it;
		it              = random_item();
		it.mode         = MODE_RESP;
		it.term_id      = planned_upload.target;
		it.resp_session = planned_upload.session;
		it.resp_index   = planned_upload.pkt_idx;
		it.ack          = '0;
		case (planned_upload.phase)
			PH_REQ:  it.resp_code = upload_cfg.request_code;
			PH_DATA: it.resp_code = upload_cfg.data_code;
			default: it.resp_code = upload_cfg.verify_code;
		endcase
		// an occasional silent tick that does not yet time out
		if (planned_upload.silent < SILENT_LIMIT && $urandom_range(0, 9) == 0)
			it.mode = MODE_TICK;
		return it;
	endfunction

	// stray starts, ticks, errors, foreign responders and stale sessions
	function automatic item_t noise_item();
		item_t it;
		it = random_item();
		case ($urandom_range(0, 9))
			0:       it.mode = MODE_START;
			1, 2:    it.mode = MODE_TICK;
			3:       it.mode = MODE_UNUSED;
			default: it.mode = MODE_RESP;
		endcase
		if ($urandom_range(0, 9) < 7)
			it.term_id = planned_upload.target;
		if ($urandom_range(0, 9) < 6)
			it.resp_session = planned_upload.session;
		case ($urandom_range(0, 3))
			0:       it.resp_code = upload_cfg.request_code;
			1:       it.resp_code = upload_cfg.data_code;
			2:       it.resp_code = upload_cfg.verify_code;
			default: ;
		endcase
		if ($urandom_range(0, 9) < 4)
			it.ack = '0;
		else if ($urandom_range(0, 5) == 0)
			it.ack = 8'hFF;
		return it;
	endfunction

	task automatic push_response(logic [5:0] code, logic [7:0] ack, logic [15:0] session,
		logic [31:0] term);
		item_t it;
		it              = random_item();
		it.mode         = MODE_RESP;
		it.resp_code    = code;
		it.ack          = ack;
		it.resp_session = session;
		it.term_id      = term;
		void'(queue_item(it));
	endtask

	// mostly complete uploads with noise mixed in; abandoned ones end by timeout
	task automatic run_uploads(int goal);
		int counted;
		int steps;
		counted = 0;
		while (counted < goal) begin
			if ($urandom_range(0, 9) < 2)
				counted += queue_item(noise_item());
			else begin
				counted += queue_item(start_item());
				steps = 0;
				while (planned_upload.phase != PH_IDLE && steps < 40) begin
					counted += queue_item(($urandom_range(0, 5) == 0) ? noise_item()
						: next_good_item());
					steps++;
				end
				while (planned_upload.phase != PH_IDLE)
					counted += queue_item(tick_item());
			end
		end
	endtask

	// wait until every item is in and every result out, then for the pipeline
	task automatic settle();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || item_valid || expected_results.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_PACKET_COUNT:  upload_cfg.packet_count  = value[15:0];
			REG_PACKET_BYTES:  upload_cfg.packet_bytes  = value[8:0];
			REG_IMAGE_CRC:     upload_cfg.image_crc     = value[15:0];
			REG_IMAGE_VERSION: upload_cfg.image_version = value;
			REG_REQUEST_CODE:  upload_cfg.request_code  = value[5:0];
			REG_DATA_CODE:     upload_cfg.data_code     = value[5:0];
			REG_VERIFY_CODE:   upload_cfg.verify_code   = value[5:0];
			REG_RESTART_CODE:  upload_cfg.restart_code  = value[5:0];
			default: ;
		endcase
	endtask

	task automatic configure(logic [15:0] count, logic [8:0] bytes, logic [15:0] crc,
		logic [31:0] version, logic [5:0] req, logic [5:0] data, logic [5:0] verify,
		logic [5:0] restart);
		settle();
		write_reg(REG_PACKET_COUNT, {16'd0, count});
		write_reg(REG_PACKET_BYTES, {23'd0, bytes});
		write_reg(REG_IMAGE_CRC, {16'd0, crc});
		write_reg(REG_IMAGE_VERSION, version);
		write_reg(REG_REQUEST_CODE, {26'd0, req});
		write_reg(REG_DATA_CODE, {26'd0, data});
		write_reg(REG_VERIFY_CODE, {26'd0, verify});
		write_reg(REG_RESTART_CODE, {26'd0, restart});
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		item_t it;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed pass on the reset configuration: one packet, codes 1 to 4.
		// Drop responses and ticks while idle, and the unused mode.
		push_response(upload_cfg.request_code, '0, '0, '0);
		void'(queue_item(tick_item()));
		it      = random_item();
		it.mode = MODE_UNUSED;
		void'(queue_item(it));
		// open a session on the highest address; a second start is dropped
		it           = start_item();
		it.target_id = '1;
		void'(queue_item(it));
		it           = start_item();
		it.target_id = '0;
		void'(queue_item(it));
		// stale session, foreign responder, unknown code, device error
		push_response(upload_cfg.request_code, '0, planned_upload.session + 16'd1,
			planned_upload.target);
		push_response(upload_cfg.request_code, '0, planned_upload.session, ~planned_upload.target);
		push_response(CODE_MASK, '0, planned_upload.session, planned_upload.target);
		push_response(upload_cfg.request_code, 8'hFF, planned_upload.session,
			planned_upload.target);
		repeat (3) void'(queue_item(tick_item()));
		// request ack clears the silent count and starts the data phase
		push_response(upload_cfg.request_code, '0, planned_upload.session, planned_upload.target);
		push_response(upload_cfg.data_code, '0, ~planned_upload.session, planned_upload.target);
		push_response(upload_cfg.data_code, 8'h80, planned_upload.session, planned_upload.target);
		push_response(upload_cfg.data_code, '0, planned_upload.session, planned_upload.target);
		// a data ack still advances the index during verify
		push_response(upload_cfg.data_code, '0, planned_upload.session, planned_upload.target);
		push_response(upload_cfg.verify_code, '0, planned_upload.session ^ 16'h8000,
			planned_upload.target);
		push_response(upload_cfg.verify_code, 8'h01, planned_upload.session,
			planned_upload.target);
		// a request ack during verify restarts data at packet zero
		push_response(upload_cfg.request_code, '0, planned_upload.session, planned_upload.target);
		push_response(upload_cfg.data_code, '0, planned_upload.session, planned_upload.target);
		push_response(upload_cfg.verify_code, '0, planned_upload.session, planned_upload.target);
		// address zero, then let it time out
		it           = start_item();
		it.target_id = '0;
		void'(queue_item(it));
		repeat (4) void'(queue_item(tick_item()));

		// extreme sizes and codes, all distinct
		configure(16'd3, 9'd256, 16'hFFFF, 32'hFFFF_FFFF, 6'h3F, 6'h00, 6'h15, 6'h2A);
		run_uploads(100);

		// every code equal: only request acks match, so uploads end by timeout
		configure(16'd1, 9'd1, 16'h0000, 32'h0000_0000, 6'd9, 6'd9, 6'd9, 6'd9);
		run_uploads(70);

		// data and verify codes coincide: data wins
		configure(16'($urandom_range(2, 6)), 9'($urandom_range(1, 256)),
			16'($urandom_range(0, 65535)), $urandom(), 6'd1, 6'd2, 6'd2, 6'h3F);
		run_uploads(90);

		// Largest image without idling: stream data acks back to back, then
		// let the session time out.
		configure(16'hFFFF, 9'd256, 16'($urandom_range(0, 65535)), $urandom(), 6'h10, 6'h20,
			6'h30, 6'h00);
		quiet = 1'b1;
		void'(queue_item(start_item()));
		push_response(upload_cfg.request_code, '0, planned_upload.session, planned_upload.target);
		repeat (40)
			push_response(upload_cfg.data_code, '0, planned_upload.session, planned_upload.target);
		while (planned_upload.phase != PH_IDLE)
			void'(queue_item(tick_item()));

		// random settings, codes free to collide
		configure(16'($urandom_range(1, 8)), 9'($urandom_range(1, 256)),
			16'($urandom_range(0, 65535)), $urandom(), 6'($urandom_range(0, 63)),
			6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
		quiet = 1'b0;
		run_uploads(90);

		settle();
		if (mismatches == 0 && expected_results.size() == 0)
			$display("tb_firmware_upload_sequencer_top passed");
		else
			$display("tb_firmware_upload_sequencer_top failed");
		$finish;
	end

endmodule

>>> filelist.f
src/fus_pkg.sv
src/fus_core.sv
src/fus_emitter.sv
src/firmware_upload_sequencer_top.sv
tb/tb_firmware_upload_sequencer_top.sv
